>>> rtl/rgb_forward_gradient_magnitude_core_macros.svh
// Assertion macros shared by the gradient core.
// Depends on nothing; included by the top level.
`ifndef RGB_FORWARD_GRADIENT_MAGNITUDE_CORE_MACROS_SVH
`define RGB_FORWARD_GRADIENT_MAGNITUDE_CORE_MACROS_SVH

// same-cycle implication
`define RGFG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RGFG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rgfg_pkg.sv
// Types and constants of the RGB forward gradient core.
// No dependencies; used by the interfaces and every module.
package rgfg_pkg;

   localparam int MAX_DIM        = 256;
   localparam int CHANNEL_BITS   = 8;
   localparam int DIM_BITS       = $clog2(MAX_DIM + 1);
   localparam int POS_BITS       = $clog2(MAX_DIM);

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam int EMIT_ABOVE = 0;
   localparam int EMIT_LEFT  = 1;
   localparam int EMIT_END   = 2;
   localparam int EMIT_COUNT = 3;

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   typedef logic [POS_BITS-1:0]     pos_type;
   typedef logic [DIM_BITS-1:0]     dim_type;
   typedef logic [EMIT_COUNT-1:0]   emit_mask_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   typedef struct packed {
      pos_type       row;
      pos_type       col;
      pixel_type     px;
      pixel_type     prev;
      pixel_type     above_self;
      pixel_type     above_right;
      emit_mask_type emit_mask;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> rtl/rgfg_if.sv
// Stream interfaces of the gradient core: pixel requests and gradient responses.
// Depends on rgfg_pkg.
interface rgfg_req_if;
   logic                       valid;
   logic                       ready;
   logic [rgfg_pkg::CHANNEL_BITS-1:0] red_in;
   logic [rgfg_pkg::CHANNEL_BITS-1:0] green_in;
   logic [rgfg_pkg::CHANNEL_BITS-1:0] blue_in;

   modport source(output valid, output red_in, output green_in, output blue_in,
                  input ready);
   modport sink(input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

interface rgfg_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rgfg_pkg::POS_BITS-1:0]     out_row;
   logic [rgfg_pkg::POS_BITS-1:0]     out_col;
   logic [rgfg_pkg::CHANNEL_BITS-1:0] red_grad;
   logic [rgfg_pkg::CHANNEL_BITS-1:0] green_grad;
   logic [rgfg_pkg::CHANNEL_BITS-1:0] blue_grad;
   logic                       run_last;

   modport source(output valid, output out_row, output out_col, output red_grad,
                  output green_grad, output blue_grad, output run_last, input ready);
   modport sink(input valid, input out_row, input out_col, input red_grad,
                input green_grad, input blue_grad, input run_last, output ready);
endinterface

>>> rtl/rgfg_front.sv
// Front end: frame size registers, raster position, line buffer and job builder.
// Depends on rgfg_pkg and rgfg_req_if.
module rgfg_front (
   input  logic                                 clock,
   input  logic                                 reset,
   rgfg_req_if.sink                             req_bus,
   input  logic                                 csr_we,
   input  logic [rgfg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rgfg_pkg::DIM_BITS-1:0]        csr_wdata,
   input  rgfg_pkg::q_status_type               q_status,
   output logic                                 job_push,
   output rgfg_pkg::job_type                    job_out
);

   rgfg_pkg::dim_type   frame_width_ff;
   rgfg_pkg::dim_type   frame_height_ff;
   rgfg_pkg::pos_type   cur_row_ff, cur_row_in;
   rgfg_pkg::pos_type   cur_col_ff, cur_col_in;
   rgfg_pkg::pixel_type prev_px_ff;
   rgfg_pkg::pixel_type rd0_ff;
   rgfg_pkg::pixel_type rd1_ff;
   rgfg_pkg::job_type   s1_job_ff, s1_job_in;
   logic                s1_right_ff, s1_right_in;
   logic                s1_valid_ff, s1_valid_in;

   rgfg_pkg::pixel_type row_store [rgfg_pkg::MAX_DIM];

   rgfg_pkg::dim_type   w_eff, h_eff;
   rgfg_pkg::dim_type   row_pre, row_k, col_next, row_next;
   rgfg_pkg::pos_type   k, j, j_right;
   rgfg_pkg::pixel_type px;
   logic                col_wrap, last_row, s1_has, advance, accept;

   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = rgfg_pkg::DIM_BITS'(1);
      end else if (frame_width_ff > rgfg_pkg::DIM_BITS'(rgfg_pkg::MAX_DIM)) begin
         w_eff = rgfg_pkg::DIM_BITS'(rgfg_pkg::MAX_DIM);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = rgfg_pkg::DIM_BITS'(1);
      end else if (frame_height_ff > rgfg_pkg::DIM_BITS'(rgfg_pkg::MAX_DIM)) begin
         h_eff = rgfg_pkg::DIM_BITS'(rgfg_pkg::MAX_DIM);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   always_comb begin
      px.red   = req_bus.red_in;
      px.green = req_bus.green_in;
      px.blue  = req_bus.blue_in;

      col_wrap = {1'b0, cur_col_ff} >= w_eff;
      row_pre  = col_wrap ? {1'b0, cur_row_ff} + rgfg_pkg::DIM_BITS'(1) : {1'b0, cur_row_ff};
      row_k    = (row_pre >= h_eff) ? '0 : row_pre;
      k        = row_k[rgfg_pkg::POS_BITS-1:0];
      j        = col_wrap ? '0 : cur_col_ff;
      j_right  = j + rgfg_pkg::POS_BITS'(1);

      col_next = {1'b0, j} + rgfg_pkg::DIM_BITS'(1);
      row_next = {1'b0, k} + rgfg_pkg::DIM_BITS'(1);
      if (col_next >= w_eff) begin
         cur_col_in = '0;
         cur_row_in = (row_next >= h_eff) ? '0 : row_next[rgfg_pkg::POS_BITS-1:0];
      end else begin
         cur_col_in = col_next[rgfg_pkg::POS_BITS-1:0];
         cur_row_in = k;
      end

      last_row = {1'b0, k} == (h_eff - rgfg_pkg::DIM_BITS'(1));

      s1_job_in                                  = s1_job_ff;
      s1_job_in.row                              = k;
      s1_job_in.col                              = j;
      s1_job_in.px                               = px;
      s1_job_in.prev                             = prev_px_ff;
      s1_job_in.emit_mask[rgfg_pkg::EMIT_ABOVE]  = k != '0;
      s1_job_in.emit_mask[rgfg_pkg::EMIT_LEFT]   = last_row && (j != '0);
      s1_job_in.emit_mask[rgfg_pkg::EMIT_END]    =
         last_row && ({1'b0, j} == (w_eff - rgfg_pkg::DIM_BITS'(1)));
      s1_right_in                                = col_next < w_eff;
   end

   always_comb begin
      s1_has          = s1_job_ff.emit_mask != '0;
      advance         = !s1_valid_ff || !s1_has || !q_status.full;
      req_bus.ready   = advance;
      accept          = req_bus.valid && advance;
      job_push        = s1_valid_ff && s1_has && !q_status.full;
      s1_valid_in     = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

      job_out             = s1_job_ff;
      job_out.above_self  = rd0_ff;
      job_out.above_right = s1_right_ff ? rd1_ff : rd0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rgfg_pkg::DIM_BITS'(rgfg_pkg::MAX_DIM);
         frame_height_ff <= rgfg_pkg::DIM_BITS'(rgfg_pkg::MAX_DIM);
         cur_row_ff      <= '0;
         cur_col_ff      <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         if (csr_we && (csr_index == rgfg_pkg::CSR_FRAME_WIDTH)) begin
            frame_width_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == rgfg_pkg::CSR_FRAME_HEIGHT)) begin
            frame_height_ff <= csr_wdata;
         end
         if (accept) begin
            cur_row_ff <= cur_row_in;
            cur_col_ff <= cur_col_in;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd0_ff         <= row_store[j];
         rd1_ff         <= row_store[j_right];
         row_store[j]   <= px;
         prev_px_ff     <= px;
         s1_job_ff      <= s1_job_in;
         s1_right_ff    <= s1_right_in;
      end
   end

endmodule

>>> rtl/rgfg_queue.sv
// Short job queue between the front end and the result sequencer.
// Depends on rgfg_pkg.
module rgfg_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_push,
   input  rgfg_pkg::job_type       job_in,
   input  logic                    job_pop,
   output rgfg_pkg::job_type       job_head,
   output rgfg_pkg::q_status_type  q_status
);

   rgfg_pkg::job_type entries_ff [rgfg_pkg::QUEUE_DEPTH];
   logic [rgfg_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rgfg_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rgfg_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      q_status.full  = count_ff == rgfg_pkg::QUEUE_CNT_BITS'(rgfg_pkg::QUEUE_DEPTH);
      q_status.empty = count_ff == '0;
      job_head       = entries_ff[rd_ptr_ff];
      wr_ptr_in      = job_push ? wr_ptr_ff + rgfg_pkg::QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in      = job_pop  ? rd_ptr_ff + rgfg_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      unique case ({job_push, job_pop})
         2'b10:   count_in = count_ff + rgfg_pkg::QUEUE_CNT_BITS'(1);
         2'b01:   count_in = count_ff - rgfg_pkg::QUEUE_CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_push) begin
         entries_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

>>> rtl/rgfg_back.sv
// Result sequencer: expands each job into its gradient words and registers them.
// Depends on rgfg_pkg and rgfg_rsp_if.
module rgfg_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rgfg_pkg::job_type       job_head,
   input  rgfg_pkg::q_status_type  q_status,
   output logic                    job_pop,
   rgfg_rsp_if.source              rsp_bus
);

   function automatic rgfg_pkg::chan_type grad_ch(input rgfg_pkg::chan_type self_v,
                                                   input rgfg_pkg::chan_type right_v,
                                                   input rgfg_pkg::chan_type below_v);
      rgfg_pkg::chan_type              dx;
      rgfg_pkg::chan_type              dy;
      logic [rgfg_pkg::CHANNEL_BITS:0] sum;
      dx  = (right_v > self_v) ? right_v - self_v : self_v - right_v;
      dy  = (below_v > self_v) ? below_v - self_v : self_v - below_v;
      sum = {1'b0, dx} + {1'b0, dy} + (rgfg_pkg::CHANNEL_BITS + 1)'(1);
      return sum[rgfg_pkg::CHANNEL_BITS:1];
   endfunction

   rgfg_pkg::emit_mask_type done_ff, done_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rgfg_pkg::pos_type       out_row_ff, out_col_ff;
   rgfg_pkg::chan_type      red_ff, green_ff, blue_ff;
   logic                    last_ff;

   rgfg_pkg::emit_mask_type pending, sel, rest;
   rgfg_pkg::pixel_type     op_self, op_right, op_below;
   rgfg_pkg::pos_type       op_row, op_col;
   logic                    load;

   always_comb begin
      pending = job_head.emit_mask & ~done_ff;
      sel     = '0;
      priority if (pending[rgfg_pkg::EMIT_ABOVE]) begin
         sel[rgfg_pkg::EMIT_ABOVE] = 1'b1;
      end else if (pending[rgfg_pkg::EMIT_LEFT]) begin
         sel[rgfg_pkg::EMIT_LEFT] = 1'b1;
      end else begin
         sel[rgfg_pkg::EMIT_END] = 1'b1;
      end
      rest    = pending & ~sel;
      load    = !q_status.empty && (!rsp_valid_ff || rsp_bus.ready);
      job_pop = load && (rest == '0);

      priority if (sel[rgfg_pkg::EMIT_ABOVE]) begin
         op_row   = job_head.row - rgfg_pkg::POS_BITS'(1);
         op_col   = job_head.col;
         op_self  = job_head.above_self;
         op_right = job_head.above_right;
         op_below = job_head.px;
      end else if (sel[rgfg_pkg::EMIT_LEFT]) begin
         op_row   = job_head.row;
         op_col   = job_head.col - rgfg_pkg::POS_BITS'(1);
         op_self  = job_head.prev;
         op_right = job_head.px;
         op_below = job_head.prev;
      end else begin
         op_row   = job_head.row;
         op_col   = job_head.col;
         op_self  = job_head.px;
         op_right = job_head.px;
         op_below = job_head.px;
      end

      done_in = done_ff;
      if (load) begin
         done_in = job_pop ? '0 : (done_ff | sel);
      end
      rsp_valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_row_ff <= op_row;
         out_col_ff <= op_col;
         red_ff     <= grad_ch(op_self.red,   op_right.red,   op_below.red);
         green_ff   <= grad_ch(op_self.green, op_right.green, op_below.green);
         blue_ff    <= grad_ch(op_self.blue,  op_right.blue,  op_below.blue);
         last_ff    <= rest == '0;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_row    = out_row_ff;
   assign rsp_bus.out_col    = out_col_ff;
   assign rsp_bus.red_grad   = red_ff;
   assign rsp_bus.green_grad = green_ff;
   assign rsp_bus.blue_grad  = blue_ff;
   assign rsp_bus.run_last   = last_ff;

endmodule

>>> rtl/rgb_forward_gradient_magnitude_core.sv
// RGB forward gradient core: raster pixels in, rounded half-L1 gradient words out.
// Path: a pixel's words pass the job stage, job queue and the response register.
// Throughput: one pixel per cycle while the queue has room; the response register
// gives one word per cycle if ready; last-row pixels can give 2 or 3 words.
// Reset: position to row 0 column 0, frame size 256 by 256, job queue empty;
// the line buffer is not cleared and holds stale pixels until rewritten.
`include "rgb_forward_gradient_magnitude_core_macros.svh"

module rgb_forward_gradient_magnitude_core (
   input  logic                                 clock,
   input  logic                                 reset,
   rgfg_req_if.sink                             req_bus,
   rgfg_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [rgfg_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rgfg_pkg::DIM_BITS-1:0]        csr_wdata
);

   rgfg_pkg::q_status_type q_status;
   rgfg_pkg::job_type      job_in;
   rgfg_pkg::job_type      job_head;
   logic                   job_push;
   logic                   job_pop;

   rgfg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .job_push  (job_push),
      .job_out   (job_in)
   );

   rgfg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .job_push (job_push),
      .job_in   (job_in),
      .job_pop  (job_pop),
      .job_head (job_head),
      .q_status (q_status)
   );

   rgfg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_head (job_head),
      .q_status (q_status),
      .job_pop  (job_pop),
      .rsp_bus  (rsp_bus)
   );

   `RGFG_ASSERT_IMP(a_push_not_full, clock, reset, job_push, !q_status.full, "job pushed into full queue")
   `RGFG_ASSERT_IMP(a_pop_not_empty, clock, reset, job_pop, !q_status.empty, "job popped from empty queue")
   `RGFG_ASSERT_IMP(a_push_has_word, clock, reset, job_push, job_in.emit_mask != '0, "queued job carries no word")
   `RGFG_ASSERT_NXT(a_pop_marks_last, clock, reset, job_pop, rsp_bus.valid && rsp_bus.run_last, "job retired without last word")

endmodule
